// ----- hdl/pidiz_pkg.sv -----
package pidiz_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    // Fixed register widths
    localparam int GAIN_W     = 16;
    localparam int ZONE_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP             = 3'd0,
        REG_KI_DT          = 3'd1,
        REG_KD_PER_DT      = 3'd2,
        REG_ACTIVE_ZONE    = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_DEAD_BAND      = 3'd5
    } t_cfg_reg;

    // Register bank as seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki_dt;
        logic [GAIN_W-1:0]  kd_per_dt;
        logic [ZONE_W-1:0]  active_zone;
        logic [LIMIT_W-1:0] integral_limit;
        logic [LIMIT_W-1:0] dead_band;
    } t_cfg;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // error: one bit above the sample, difference of errors: two bits
    function automatic int f_err_w(input int sw);
        return sw + 1;
    endfunction

    function automatic int f_diff_w(input int sw);
        return sw + 2;
    endfunction

    // unsigned gain times signed error, exact
    function automatic int f_prod_w(input int sw);
        return GAIN_W + f_err_w(sw) + 1;
    endfunction

    function automatic int f_dprod_w(input int sw);
        return GAIN_W + f_diff_w(sw) + 1;
    endfunction

    // clamped integral, scaled by the gain fraction
    function automatic int f_integ_w(input int gf);
        return LIMIT_W + gf + 1;
    endfunction

    // P + I + D accumulator
    function automatic int f_sum_w(input int sw, input int gf);
        return f_max(f_max(f_prod_w(sw), f_dprod_w(sw)), f_integ_w(gf)) + 2;
    endfunction

endpackage

// ----- hdl/pidiz_cfg.sv -----
module pidiz_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pidiz_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pidiz_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pidiz_pkg::t_cfg                  o_cfg
);
    import pidiz_pkg::*;

    t_cfg r_cfg;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register bank; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_KP:             r_cfg.kp             <= i_cfg_data[GAIN_W-1:0];
                REG_KI_DT:          r_cfg.ki_dt          <= i_cfg_data[GAIN_W-1:0];
                REG_KD_PER_DT:      r_cfg.kd_per_dt      <= i_cfg_data[GAIN_W-1:0];
                REG_ACTIVE_ZONE:    r_cfg.active_zone    <= i_cfg_data[ZONE_W-1:0];
                REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_DEAD_BAND:      r_cfg.dead_band      <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/pidiz_front.sv -----
module pidiz_front #(
    parameter int SAMPLE_WIDTH = pidiz_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pidiz_pkg::t_cfg         i_cfg,
    // input word
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_target,
    input  logic signed [SAMPLE_WIDTH-1:0] i_measured,
    input  logic                    i_enable,
    // products towards the integral stage
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_enable,
    output logic                    o_in_zone,
    output logic signed [pidiz_pkg::f_prod_w(SAMPLE_WIDTH)-1:0]  o_p,
    output logic signed [pidiz_pkg::f_prod_w(SAMPLE_WIDTH)-1:0]  o_kid,
    output logic signed [pidiz_pkg::f_dprod_w(SAMPLE_WIDTH)-1:0] o_d
);
    import pidiz_pkg::*;

    localparam int EW   = f_err_w(SAMPLE_WIDTH);
    localparam int DW   = f_diff_w(SAMPLE_WIDTH);
    localparam int PW   = f_prod_w(SAMPLE_WIDTH);
    localparam int DPW  = f_dprod_w(SAMPLE_WIDTH);
    localparam int CMPW = f_max(EW, ZONE_W);

    logic                 r_v1, r_en1;
    logic signed [EW-1:0] r_err1;
    logic signed [DW-1:0] r_diff1;
    logic signed [EW-1:0] r_last_err;

    logic                  r_v2, r_en2, r_zone2;
    logic signed [PW-1:0]  r_p2, r_kid2;
    logic signed [DPW-1:0] r_d2;

    logic                  ready1, ready2, accept;
    logic signed [EW-1:0]  err_in;
    logic signed [DW-1:0]  diff_in;
    logic [EW-1:0]         err_mag;
    logic                  in_zone;
    logic signed [PW-1:0]  p_mul, kid_mul;
    logic signed [DPW-1:0] d_mul;

    // stage occupancy and back pressure
    assign ready2     = !r_v2 || i_ready;
    assign ready1     = !r_v1 || ready2;
    assign accept     = i_in_valid && ready1;
    assign o_in_stall = !ready1;

    // error taken straight off the ports; error step against the last enabled error
    assign err_in  = EW'(i_target) - EW'(i_measured);
    assign diff_in = DW'(err_in) - DW'(r_last_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_last_err <= '0;
        end else begin
            if (ready1) begin
                r_v1 <= i_in_valid;
            end
            if (accept && i_enable) begin
                r_last_err <= err_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_en1   <= i_enable;
            r_err1  <= err_in;
            r_diff1 <= diff_in;
        end
    end

    // zone test and the three gain products
    assign err_mag = r_err1[EW-1] ? EW'(-r_err1) : EW'(r_err1);
    assign in_zone = CMPW'(err_mag) <= CMPW'(i_cfg.active_zone);
    assign p_mul   = $signed({1'b0, i_cfg.kp}) * r_err1;
    assign kid_mul = $signed({1'b0, i_cfg.ki_dt}) * r_err1;
    assign d_mul   = $signed({1'b0, i_cfg.kd_per_dt}) * r_diff1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ready2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_en2   <= r_en1;
            r_zone2 <= in_zone;
            r_p2    <= p_mul;
            r_kid2  <= kid_mul;
            r_d2    <= d_mul;
        end
    end

    assign o_valid   = r_v2;
    assign o_enable  = r_en2;
    assign o_in_zone = r_zone2;
    assign o_p       = r_p2;
    assign o_kid     = r_kid2;
    assign o_d       = r_d2;

endmodule

// ----- hdl/pidiz_integ.sv -----
module pidiz_integ #(
    parameter int SAMPLE_WIDTH   = pidiz_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pidiz_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pidiz_pkg::t_cfg         i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_enable,
    input  logic                    i_in_zone,
    input  logic signed [pidiz_pkg::f_prod_w(SAMPLE_WIDTH)-1:0]  i_p,
    input  logic signed [pidiz_pkg::f_prod_w(SAMPLE_WIDTH)-1:0]  i_kid,
    input  logic signed [pidiz_pkg::f_dprod_w(SAMPLE_WIDTH)-1:0] i_d,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [pidiz_pkg::f_sum_w(SAMPLE_WIDTH, GAIN_FRAC_BITS)-1:0] o_sum
);
    import pidiz_pkg::*;

    localparam int PW   = f_prod_w(SAMPLE_WIDTH);
    localparam int IW   = f_integ_w(GAIN_FRAC_BITS);
    localparam int IAW  = f_max(IW, PW) + 1;
    localparam int SUMW = f_sum_w(SAMPLE_WIDTH, GAIN_FRAC_BITS);

    logic signed [IW-1:0]   r_integral;
    logic                   r_v3;
    logic signed [SUMW-1:0] r_sum3;

    logic                   ready3, move;
    logic signed [IAW-1:0]  acc, lim, neg_lim, clamped;
    logic signed [IW-1:0]   integ_next;
    logic signed [SUMW-1:0] pd, sum_next;

    assign ready3  = !r_v3 || i_ready;
    assign o_ready = ready3;
    assign move    = i_valid && ready3;

    // accumulate, then clamp to +/- limit scaled to the integral's format
    assign acc     = IAW'(r_integral) + IAW'(i_kid);
    assign lim     = IAW'(i_cfg.integral_limit) << GAIN_FRAC_BITS;
    assign neg_lim = -lim;

    always_comb begin
        priority if (acc >= lim) begin
            clamped = lim;
        end else if (acc <= neg_lim) begin
            clamped = neg_lim;
        end else begin
            clamped = acc;
        end
    end

    // leaving the zone clears the integral
    assign integ_next = i_in_zone ? clamped[IW-1:0] : '0;

    // P + I + D; a disabled word carries a zero sum
    assign pd       = SUMW'(i_p) + SUMW'(i_d);
    assign sum_next = i_enable ? (pd + SUMW'(integ_next)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3       <= 1'b0;
            r_integral <= '0;
        end else begin
            if (ready3) begin
                r_v3 <= i_valid;
            end
            if (move && i_enable) begin
                r_integral <= integ_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_sum3 <= sum_next;
        end
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum3;

endmodule

// ----- hdl/pidiz_out.sv -----
module pidiz_out #(
    parameter int SAMPLE_WIDTH   = pidiz_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pidiz_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pidiz_pkg::t_cfg         i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [pidiz_pkg::f_sum_w(SAMPLE_WIDTH, GAIN_FRAC_BITS)-1:0] i_sum,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_drive,
    output logic                    o_saturated
);
    import pidiz_pkg::*;

    localparam int SUMW = f_sum_w(SAMPLE_WIDTH, GAIN_FRAC_BITS);
    localparam int RW   = SUMW + 1;
    localparam int CW   = f_max(SAMPLE_WIDTH, LIMIT_W);
    localparam logic [RW-1:0] HALF    = RW'((1 << GAIN_FRAC_BITS) >> 1);
    localparam logic [RW-1:0] NEG_MAX = RW'(1) << (SAMPLE_WIDTH - 1);
    localparam logic [RW-1:0] POS_MAX = NEG_MAX - RW'(1);

    logic                          r_v4, r_sat4;
    logic signed [SAMPLE_WIDTH-1:0] r_drive4;

    logic                    ready4, move, neg, sat;
    logic [SUMW-1:0]         mag;
    logic [RW-1:0]           rounded;
    logic [SAMPLE_WIDTH-1:0] dmag, drive_next;
    logic                    dead;

    assign ready4  = !r_v4 || !i_out_stall;
    assign o_ready = ready4;
    assign move    = i_valid && ready4;

    // round the magnitude half away from zero
    assign neg     = i_sum[SUMW-1];
    assign mag     = neg ? SUMW'(-i_sum) : SUMW'(i_sum);
    assign rounded = (RW'(mag) + HALF) >> GAIN_FRAC_BITS;

    // saturate to the sample range
    assign sat  = neg ? (rounded > NEG_MAX) : (rounded > POS_MAX);
    assign dmag = sat ? (neg ? NEG_MAX[SAMPLE_WIDTH-1:0] : POS_MAX[SAMPLE_WIDTH-1:0])
                      : rounded[SAMPLE_WIDTH-1:0];

    // deadband on the saturated magnitude
    assign dead       = CW'(dmag) < CW'(i_cfg.dead_band);
    assign drive_next = dead ? '0 : (neg ? -dmag : dmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (ready4) begin
            r_v4 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_drive4 <= drive_next;
            r_sat4   <= sat;
        end
    end

    assign o_out_valid = r_v4;
    assign o_drive     = r_drive4;
    assign o_saturated = r_sat4;

endmodule

// ----- hdl/pid_controller_with_izone.sv -----
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall  | i_target, i_measured, i_enable
// output  | out       | o_out_valid / i_out_stall| o_drive, o_saturated
// config  | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One word per cycle unless the output stalls; each word passes through four
// register stages (input/error, gain products, integral and sum,
// round/saturate/deadband) before it shows on o_drive with o_out_valid.
// The integral register closes its loop inside the third stage.
// Reset (synchronous, i_rst_n low) clears valid flags, config, integral and last error.
// Each stage holds only when it is full and the one after it holds; the hold
// ripples back combinationally, so o_in_stall follows i_out_stall in the same
// cycle once every stage is full.
module pid_controller_with_izone #(
    parameter int SAMPLE_WIDTH   = pidiz_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pidiz_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pidiz_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pidiz_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_target,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_measured,
    input  logic                             i_enable,
    // result words
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]   o_drive,
    output logic                             o_saturated
);
    import pidiz_pkg::*;

    localparam int PW   = f_prod_w(SAMPLE_WIDTH);
    localparam int DPW  = f_dprod_w(SAMPLE_WIDTH);
    localparam int SUMW = f_sum_w(SAMPLE_WIDTH, GAIN_FRAC_BITS);

    t_cfg cfg;

    logic                   prod_valid, prod_ready, prod_enable, prod_zone;
    logic signed [PW-1:0]   prod_p, prod_kid;
    logic signed [DPW-1:0]  prod_d;
    logic                   sum_valid, sum_ready;
    logic signed [SUMW-1:0] sum;

    pidiz_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pidiz_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_target   (i_target),
        .i_measured (i_measured),
        .i_enable   (i_enable),
        .o_valid    (prod_valid),
        .i_ready    (prod_ready),
        .o_enable   (prod_enable),
        .o_in_zone  (prod_zone),
        .o_p        (prod_p),
        .o_kid      (prod_kid),
        .o_d        (prod_d)
    );

    pidiz_integ #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_integ (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_valid   (prod_valid),
        .o_ready   (prod_ready),
        .i_enable  (prod_enable),
        .i_in_zone (prod_zone),
        .i_p       (prod_p),
        .i_kid     (prod_kid),
        .i_d       (prod_d),
        .o_valid   (sum_valid),
        .i_ready   (sum_ready),
        .o_sum     (sum)
    );

    pidiz_out #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (sum_valid),
        .o_ready     (sum_ready),
        .i_sum       (sum),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .o_saturated (o_saturated)
    );

endmodule
